/* hdl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Operation codes, payload widths and the control word of a cell row.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_WORD_WIDTH = 64;

	localparam int OP_W   = 3;
	localparam int DATA_W = 64;
	localparam int OCC_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_REVERSE    = 3'd4,
		OP_QUERY      = 3'd5
	} op_t;

	typedef logic [OP_W-1:0]   op_code_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [OCC_W-1:0]  occ_t;

	// per-cycle command broadcast along one row of cells
	typedef struct packed {
		logic shift_up;   // every cell takes its lower neighbor, cell 0 takes the new word
		logic shift_down; // every cell takes its upper neighbor
		logic insert;     // the cell whose index equals the count takes the new word
	} row_ctl_t;

endpackage

/* hdl/dq_req_if.sv */
// ----------------------------------------------------------------------------
// dq_req_if: operation channel
// Valid/ready channel carrying one queue operation and its word.
// ----------------------------------------------------------------------------
interface dq_req_if;
	logic              valid;
	logic              ready;
	dq_pkg::op_code_t  op;
	dq_pkg::data_t     value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

/* hdl/dq_rsp_if.sv */
// ----------------------------------------------------------------------------
// dq_rsp_if: result channel
// Valid/ready channel carrying the queue status after one operation.
// ----------------------------------------------------------------------------
interface dq_rsp_if;
	logic          valid;
	logic          ready;
	dq_pkg::data_t front_word;
	dq_pkg::data_t back_word;
	dq_pkg::occ_t  occupancy;
	logic          is_empty;
	logic          op_error;

	modport source (output valid, output front_word, output back_word, output occupancy,
		output is_empty, output op_error, input ready);
	modport sink   (input valid, input front_word, input back_word, input occupancy,
		input is_empty, input op_error, output ready);
endinterface

/* hdl/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue
// Operations arrive on req (op, value); one status result per operation
// leaves on rsp (front_word, back_word, occupancy, is_empty, op_error).
// An operation is a transfer on req when valid and ready are high. It is
// applied at that clock edge and its result is presented on rsp from the
// next cycle on; one operation can be taken every cycle while rsp keeps
// up. When rsp stalls, req.ready drops until the waiting result has been
// transferred; the queue does not change.
// The words are kept twice, in two rows of cells: one row has the low end
// of the queue in its first cell, the other row the high end. A push shifts
// the row of its own end and drops the word into the other row just past
// its last word; a pop shifts its own row only. Both ends are thus always
// in a fixed cell. Reverse flips which physical end is the front.
// Errors (pop or reverse when empty, push when full) leave the queue as is.
// Reset empties the queue and clears the direction; stored words keep
// whatever they hold and are never shown while unwritten.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
	parameter int CAPACITY   = dq_pkg::DEF_CAPACITY,
	parameter int WORD_WIDTH = dq_pkg::DEF_WORD_WIDTH
) (
	input  logic    clk,
	input  logic    arst_n,
	dq_req_if.sink  req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]      count_q;
	logic                  rev_q;
	logic                  rsp_valid_q;
	logic                  err_q;

	logic                  xfer;
	logic                  full;
	logic                  empty;
	logic                  fwd;
	logic [WORD_WIDTH-1:0] new_word;
	row_ctl_t              low_ctl;
	row_ctl_t              high_ctl;
	logic                  err;
	logic [CNT_W-1:0]      count_d;
	logic                  rev_d;
	logic [WORD_WIDTH-1:0] low_word;
	logic [WORD_WIDTH-1:0] high_word;
	logic [WORD_WIDTH-1:0] front_w;
	logic [WORD_WIDTH-1:0] back_w;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign xfer      = req.valid && req.ready;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign empty     = count_q == '0;
	assign fwd       = !rev_q;
	assign new_word  = req.value[WORD_WIDTH-1:0];

	always_comb begin
		low_ctl  = '0;
		high_ctl = '0;
		err      = 1'b0;
		count_d  = count_q;
		rev_d    = rev_q;
		unique case (op_t'(req.op))
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					err = 1'b1;
				end else begin
					// low end takes the push when front and forward agree
					if ((op_t'(req.op) == OP_PUSH_FRONT) == fwd) begin
						low_ctl.shift_up = 1'b1;
						high_ctl.insert  = 1'b1;
					end else begin
						high_ctl.shift_up = 1'b1;
						low_ctl.insert    = 1'b1;
					end
					count_d = count_q + 1'b1;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					if ((op_t'(req.op) == OP_POP_FRONT) == fwd) begin
						low_ctl.shift_down = 1'b1;
					end else begin
						high_ctl.shift_down = 1'b1;
					end
					count_d = count_q - 1'b1;
				end
			end
			OP_REVERSE: begin
				if (empty) begin
					err = 1'b1;
				end else begin
					rev_d = !rev_q;
				end
			end
			default: begin
			end
		endcase
		if (!xfer) begin
			low_ctl  = '0;
			high_ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rev_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			err_q       <= 1'b0;
		end else begin
			if (xfer) begin
				count_q <= count_d;
				rev_q   <= rev_d;
				err_q   <= err;
			end
			if (xfer) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	dq_row #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_low_row (
		.clk      (clk),
		.ctl      (low_ctl),
		.count    (count_q),
		.new_word (new_word),
		.end_word (low_word)
	);

	dq_row #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_high_row (
		.clk      (clk),
		.ctl      (high_ctl),
		.count    (count_q),
		.new_word (new_word),
		.end_word (high_word)
	);

	// result is read straight from the state registers; they hold while it waits
	always_comb begin
		if (empty) begin
			front_w = '0;
			back_w  = '0;
		end else if (rev_q) begin
			front_w = high_word;
			back_w  = low_word;
		end else begin
			front_w = low_word;
			back_w  = high_word;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.front_word = DATA_W'(front_w);
	assign rsp.back_word  = DATA_W'(back_w);
	assign rsp.occupancy  = OCC_W'(count_q);
	assign rsp.is_empty   = empty;
	assign rsp.op_error   = err_q;

endmodule

/* hdl/dq_cell.sv */
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of a row
// Holds one word; shifts from either neighbor or loads the new word.
// ----------------------------------------------------------------------------
module dq_cell #(
	parameter int WORD_WIDTH = dq_pkg::DEF_WORD_WIDTH
) (
	input  logic                  clk,
	input  dq_pkg::row_ctl_t      ctl,
	input  logic                  hit,
	input  logic [WORD_WIDTH-1:0] new_word,
	input  logic [WORD_WIDTH-1:0] lower_word,
	input  logic [WORD_WIDTH-1:0] upper_word,
	output logic [WORD_WIDTH-1:0] word
);
	import dq_pkg::*;

	logic [WORD_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_up) begin
			word_q <= lower_word;
		end else if (ctl.shift_down) begin
			word_q <= upper_word;
		end else if (ctl.insert && hit) begin
			word_q <= new_word;
		end
	end

	assign word = word_q;

endmodule

/* hdl/dq_row.sv */
// ----------------------------------------------------------------------------
// dq_row: row of storage cells
// Cell 0 holds the end of the queue seen from this row; data steps one cell
// per cycle on a shift, and an insert lands in the cell just past the last word.
// ----------------------------------------------------------------------------
module dq_row #(
	parameter int CAPACITY   = dq_pkg::DEF_CAPACITY,
	parameter int WORD_WIDTH = dq_pkg::DEF_WORD_WIDTH,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  dq_pkg::row_ctl_t      ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [WORD_WIDTH-1:0] new_word,
	output logic [WORD_WIDTH-1:0] end_word
);
	import dq_pkg::*;

	logic [WORD_WIDTH-1:0] words [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] lower;
		logic [WORD_WIDTH-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = new_word;
		end else begin : g_mid
			assign lower = words[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign upper = words[i];
		end else begin : g_inner
			assign upper = words[i+1];
		end

		dq_cell #(
			.WORD_WIDTH(WORD_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.hit        (count == CNT_W'(i)),
			.new_word   (new_word),
			.lower_word (lower),
			.upper_word (upper),
			.word       (words[i])
		);
	end

	assign end_word = words[0];

endmodule

/* bench/double_ended_queue_unit_tb.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_unit_tb: self-checking bench of the double-ended queue
// Drives push, pop, reverse and query operations on the req channel and
// checks every status result against a behavioral queue kept in the bench.
// Directed extremes come first, then biased random traffic with bursts of
// idle on both channels, a drained phase and a back-to-back phase.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_tb;

	import dq_pkg::*;

	localparam int CAPACITY    = DEF_CAPACITY;
	localparam int CYCLE_LIMIT = 400000;

	// op codes outside the defined set, treated as a query
	localparam op_code_t OP_SPARE_LO = 3'd6;
	localparam op_code_t OP_SPARE_HI = 3'd7;

	typedef struct {
		data_t    front_word;
		data_t    back_word;
		occ_t     occupancy;
		logic     is_empty;
		logic     op_error;
	} status_t;

	logic clk;
	logic arst_n;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue_unit #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (DEF_WORD_WIDTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	data_t   held_words[$];
	status_t pending_status[$];

	bit idle_on;
	int mismatch_count;
	int ops_sent;
	int ops_refused;
	int results_checked;
	int cycle_count;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("double_ended_queue_unit verification failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input data_t got, input data_t want);
		$display("mismatch @%0d %s: got %h expected %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// apply one operation to the bench copy of the queue, return the status after it
	function automatic status_t compute_status(op_code_t op, data_t value);
		status_t s;
		data_t   flipped[$];
		s.op_error = 1'b0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (held_words.size() >= CAPACITY)
					s.op_error = 1'b1;
				else if (op == OP_PUSH_FRONT)
					held_words.push_front(value);
				else
					held_words.push_back(value);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (held_words.size() == 0)
					s.op_error = 1'b1;
				else if (op == OP_POP_FRONT)
					void'(held_words.pop_front());
				else
					void'(held_words.pop_back());
			end
			OP_REVERSE: begin
				if (held_words.size() == 0) begin
					s.op_error = 1'b1;
				end else begin
					foreach (held_words[i]) flipped.push_front(held_words[i]);
					held_words = flipped;
				end
			end
			default: ;
		endcase
		s.occupancy = occ_t'(held_words.size());
		s.is_empty = (held_words.size() == 0);
		s.front_word = s.is_empty ? '0 : held_words[0];
		s.back_word = s.is_empty ? '0 : held_words[$];
		return s;
	endfunction

	task automatic send_op(input op_code_t op, input data_t value);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_status.push_back(compute_status(op, value));
		ops_sent++;
		if (pending_status[$].op_error) ops_refused++;
	endtask

	// hold the sender off until every result is back
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
	endtask

	function automatic data_t random_word();
		data_t w;
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = '1;
			2: w = data_t'(1) << $urandom_range(0, DATA_W - 1);
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	function automatic op_code_t random_op(bit fill_bias);
		int r;
		r = $urandom_range(0, 99);
		if (fill_bias) begin
			if (r < 35) return OP_PUSH_FRONT;
			if (r < 70) return OP_PUSH_BACK;
			if (r < 80) return OP_POP_FRONT;
			if (r < 88) return OP_POP_BACK;
			if (r < 94) return OP_REVERSE;
		end else begin
			if (r < 12) return OP_PUSH_FRONT;
			if (r < 24) return OP_PUSH_BACK;
			if (r < 55) return OP_POP_FRONT;
			if (r < 86) return OP_POP_BACK;
			if (r < 93) return OP_REVERSE;
		end
		if (r < 97) return OP_QUERY;
		return op_code_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
	endfunction

	// result side: random stalls when idling is on
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= $urandom_range(1, 3) - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_status.size() == 0) begin
				report_mismatch("result with nothing pending", data_t'(rsp_ch.occupancy),
					'0);
			end else begin
				want = pending_status.pop_front();
				results_checked++;
				if (rsp_ch.front_word !== want.front_word)
					report_mismatch("front_word", rsp_ch.front_word, want.front_word);
				if (rsp_ch.back_word !== want.back_word)
					report_mismatch("back_word", rsp_ch.back_word, want.back_word);
				if (rsp_ch.occupancy !== want.occupancy)
					report_mismatch("occupancy", data_t'(rsp_ch.occupancy),
						data_t'(want.occupancy));
				if (rsp_ch.is_empty !== want.is_empty)
					report_mismatch("is_empty", data_t'(rsp_ch.is_empty),
						data_t'(want.is_empty));
				if (rsp_ch.op_error !== want.op_error)
					report_mismatch("op_error", data_t'(rsp_ch.op_error),
						data_t'(want.op_error));
			end
		end
	end

	task automatic test_empty_refusals();
		send_op(OP_POP_FRONT, '1);
		send_op(OP_POP_BACK, '1);
		send_op(OP_REVERSE, '0);
		send_op(OP_QUERY, '1);
		send_op(OP_SPARE_LO, '1);
		send_op(OP_SPARE_HI, '0);
	endtask

	// fill to capacity from both ends, then refuse pushes and flip
	task automatic test_fill_to_full();
		data_t patterns[8];
		patterns = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0000, 64'h1,
			64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210};
		for (int i = 0; i < CAPACITY; i++)
			send_op(i % 2 ? OP_PUSH_BACK : OP_PUSH_FRONT, patterns[i % 8] ^ data_t'(i / 8));
		send_op(OP_PUSH_FRONT, '1);
		send_op(OP_PUSH_BACK, '0);
		send_op(OP_REVERSE, '1);
	endtask

	task automatic test_random_mix(input int n);
		bit fill_bias;
		int run_left;
		run_left = 0;
		fill_bias = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (run_left == 0) begin
				fill_bias = ~fill_bias;
				run_left = $urandom_range(10, 40);
			end
			run_left--;
			send_op(random_op(fill_bias), random_word());
		end
	endtask

	task automatic test_drained_bursts(input int n);
		for (int i = 0; i < n; i++) begin
			send_op(random_op(1'($urandom_range(0, 1))), random_word());
			if ($urandom_range(0, 7) == 0) drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		idle_on = 1'b0;
		stall_left = 0;
		cycle_count = 0;
		mismatch_count = 0;
		ops_sent = 0;
		ops_refused = 0;
		results_checked = 0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_QUERY;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		idle_on = 1'b1;
		test_empty_refusals();
		test_fill_to_full();
		test_random_mix(1300);
		test_drained_bursts(200);
		idle_on = 1'b0;
		test_random_mix(300);

		drain_results();
		repeat (5) @(posedge clk);
		$display("%0d operations sent, %0d refused for empty or full, %0d results checked",
			ops_sent, ops_refused, results_checked);
		$display("covered both ends, reverse, full and empty refusals, spare op codes, stalls");
		if (mismatch_count == 0)
			$display("double_ended_queue_unit verification clean");
		else
			$display("double_ended_queue_unit verification failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/dq_pkg.sv
hdl/dq_req_if.sv
hdl/dq_rsp_if.sv
hdl/dq_cell.sv
hdl/dq_row.sv
hdl/double_ended_queue_unit.sv
bench/double_ended_queue_unit_tb.sv
